[src/assert_macros.svh]
// Assertion macros for the bus decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cbrm_pkg.sv]
// Shared constants and helpers for the console bus decoder
package cbrm_pkg;

  localparam logic [22:0] MAX_ROM_BYTES = 23'h400000;

  localparam logic [3:0] T_ROM    = 4'd0;
  localparam logic [3:0] T_BRAM   = 4'd1;
  localparam logic [3:0] T_WRAM   = 4'd2;
  localparam logic [3:0] T_VIDEO  = 4'd3;
  localparam logic [3:0] T_COLOUR = 4'd4;
  localparam logic [3:0] T_SOUND  = 4'd5;
  localparam logic [3:0] T_TIMER  = 4'd6;
  localparam logic [3:0] T_PAD    = 4'd7;
  localparam logic [3:0] T_IRQ    = 4'd8;
  localparam logic [3:0] T_OPEN   = 4'd9;

  localparam logic [2:0] IO_VIDEO  = 3'd0;
  localparam logic [2:0] IO_COLOUR = 3'd1;
  localparam logic [2:0] IO_SOUND  = 3'd2;
  localparam logic [2:0] IO_TIMER  = 3'd3;
  localparam logic [2:0] IO_PAD    = 3'd4;
  localparam logic [2:0] IO_IRQ    = 3'd5;

  localparam logic [22:0] SIZE_384K = 23'h060000;
  localparam logic [22:0] SIZE_1M   = 23'h100000;
  localparam logic [7:0]  OPEN_BUS  = 8'hFF;

  function automatic logic [7:0] pad_byte(input logic [7:0] lines, input logic sel,
                                          input logic clr);
    logic [7:0] p;
    logic [3:0] d;
    p = clr ? 8'h00 : lines;
    d = sel ? p[7:4] : p[3:0];
    return {4'h3, d};
  endfunction

endpackage

[src/console_bus_decoder_rom_mapper_unit.sv]
// Console bus decoder and banked ROM mapper, top level.
// An item passes the decode state, the divide state of the shared restoring
// subtractor (only ROM reads of images that wrap by modulo), and the finish
// state, which registers the result. No new item is taken while busy; busy
// stays high until the result is out. Reset: a clearing pass zeroes work
// and backup RAM; busy is high until it ends. The receiver cannot stall.
`include "assert_macros.svh"

module console_bus_decoder_rom_mapper_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [20:0] addr,
  input  logic [7:0]  write_data,
  input  logic [7:0]  pad_lines,
  input  logic        cfg_we,
  input  logic [22:0] cfg_data,
  output logic        done,
  output logic [3:0]  target,
  output logic [7:0]  read_data,
  output logic [21:0] rom_address,
  output logic [3:0]  device_offset,
  output logic        is_write
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]  state;
  logic [12:0] clr_idx;
  logic        func_q;
  logic [20:0] addr_q;
  logic [7:0]  wdata_q;
  logic [7:0]  lines_q;
  logic [22:0] rom_size;
  logic [1:0]  upper_bank;
  logic        pad_select;
  logic        pad_clear;
  logic [21:0] base;
  logic [19:0] rem;
  logic [20:0] div;
  logic [4:0]  cnt;

  logic [7:0] work_ram [8192];
  logic [7:0] backup_ram [2048];
  logic [7:0] wram_q;
  logic [7:0] bram_q;

  logic [7:0]  bank;
  logic        rom_bank, bram_hit, wram_hit, io_hit;
  logic [2:0]  io_slot;
  logic [22:0] size_img;
  logic        big, is384, mod_path;
  logic [21:0] base_direct;
  logic [4:0]  msb;
  logic [4:0]  shamt;
  logic [20:0] div_init;
  logic        sub_ok;
  logic [22:0] off;

  logic        wram_we, bram_we;
  logic [12:0] wram_a;
  logic [10:0] bram_a;
  logic [7:0]  ram_d;

  logic [3:0]  target_next;
  logic [7:0]  rd_next;
  logic [21:0] romaddr_next;
  logic [3:0]  devoff_next;

  assign busy = (state != S_IDLE);

  assign bank     = addr_q[20:13];
  assign rom_bank = ~bank[7];
  assign bram_hit = (bank == 8'hF7);
  assign wram_hit = (bank[7:2] == 6'h3E);
  assign io_hit   = (bank == 8'hFF);
  assign io_slot  = addr_q[12:10];

  assign size_img = (rom_size > cbrm_pkg::MAX_ROM_BYTES) ? cbrm_pkg::MAX_ROM_BYTES : rom_size;
  assign big      = (size_img > cbrm_pkg::SIZE_1M);
  assign is384    = (size_img == cbrm_pkg::SIZE_384K);
  assign mod_path = rom_bank && !func_q && (size_img != 23'd0) && !big && !is384;

  always_comb begin
    if (is384) begin
      if (bank[5:0] < 6'h20) base_direct = {3'b0, bank[5:0], 13'b0};
      else base_direct = 22'h040000 + {5'b0, bank[3:0], 13'b0};
    end else if (bank[6] == 1'b0) begin
      base_direct = {2'b0, bank[6:0], 13'b0};
    end else begin
      base_direct = {3'({1'b0, upper_bank} + 3'd1), 19'b0} + {3'b0, bank[5:0], 13'b0};
    end
  end

  // Normalize divisor so its top bit sits at bit 20
  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 21; i++) begin
      if (size_img[i]) msb = 5'(i);
    end
  end
  assign shamt    = 5'd20 - msb;
  assign div_init = size_img[20:0] << shamt;
  assign sub_ok   = ({1'b0, rem} >= div);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= 13'd0;
      rom_size   <= 23'd0;
      upper_bank <= 2'd0;
      pad_select <= 1'b0;
      pad_clear  <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (cfg_we) rom_size <= cfg_data;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 13'd1;
          if (clr_idx == 13'h1FFF) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) state <= S_DECODE;
        end
        S_DECODE: begin
          if (func_q && rom_bank && big && (addr_q[12:2] == 11'h7FC)) begin
            upper_bank <= addr_q[1:0];
          end
          if (func_q && io_hit && (io_slot == cbrm_pkg::IO_PAD)) begin
            pad_select <= wdata_q[0];
            pad_clear  <= wdata_q[1];
          end
          if (mod_path) state <= S_DIV;
          else state <= S_DONE;
        end
        S_DIV: begin
          if (cnt == 5'd0) state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item capture and shared restoring subtractor
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      func_q  <= func;
      addr_q  <= addr;
      wdata_q <= write_data;
      lines_q <= pad_lines;
    end
    if (state == S_DECODE) begin
      base <= base_direct;
      rem  <= {bank[6:0], 13'b0};
      div  <= div_init;
      cnt  <= shamt;
    end else if (state == S_DIV) begin
      if (sub_ok) begin
        rem  <= rem - div[19:0];
        base <= {2'b0, rem - div[19:0]};
      end else begin
        base <= {2'b0, rem};
      end
      div <= div >> 1;
      cnt <= cnt - 5'd1;
    end
  end

  assign ram_d   = (state == S_CLEAR) ? 8'h00 : wdata_q;
  assign wram_we = (state == S_CLEAR) || (state == S_DECODE && wram_hit && func_q);
  assign bram_we = (state == S_CLEAR) || (state == S_DECODE && bram_hit && func_q);
  assign wram_a  = (state == S_CLEAR) ? clr_idx : addr_q[12:0];
  assign bram_a  = (state == S_CLEAR) ? clr_idx[10:0] : addr_q[10:0];

  always_ff @(posedge clk) begin
    if (wram_we) work_ram[wram_a] <= ram_d;
    wram_q <= work_ram[addr_q[12:0]];
  end

  always_ff @(posedge clk) begin
    if (bram_we) backup_ram[bram_a] <= ram_d;
    bram_q <= backup_ram[addr_q[10:0]];
  end

  assign off = {1'b0, base} + {10'b0, addr_q[12:0]};

  always_comb begin
    target_next  = cbrm_pkg::T_OPEN;
    rd_next      = 8'h00;
    romaddr_next = 22'd0;
    devoff_next  = 4'd0;
    if (rom_bank) begin
      if (func_q) begin
        target_next = cbrm_pkg::T_ROM;
      end else if (size_img != 23'd0 && off < size_img) begin
        target_next  = cbrm_pkg::T_ROM;
        romaddr_next = off[21:0];
      end else begin
        rd_next = cbrm_pkg::OPEN_BUS;
      end
    end else if (bram_hit) begin
      target_next = cbrm_pkg::T_BRAM;
      if (!func_q) rd_next = bram_q;
    end else if (wram_hit) begin
      target_next = cbrm_pkg::T_WRAM;
      if (!func_q) rd_next = wram_q;
    end else if (io_hit) begin
      case (io_slot)
        cbrm_pkg::IO_VIDEO: begin
          target_next = cbrm_pkg::T_VIDEO;
          devoff_next = {2'b0, addr_q[1:0]};
        end
        cbrm_pkg::IO_COLOUR: begin
          target_next = cbrm_pkg::T_COLOUR;
          devoff_next = {1'b0, addr_q[2:0]};
        end
        cbrm_pkg::IO_SOUND: begin
          if (func_q) begin
            target_next = cbrm_pkg::T_SOUND;
            devoff_next = addr_q[3:0];
          end else begin
            rd_next = cbrm_pkg::OPEN_BUS;
          end
        end
        cbrm_pkg::IO_TIMER: begin
          target_next = cbrm_pkg::T_TIMER;
          devoff_next = {3'b0, func_q & addr_q[0]};
        end
        cbrm_pkg::IO_PAD: begin
          target_next = cbrm_pkg::T_PAD;
          if (!func_q) rd_next = cbrm_pkg::pad_byte(lines_q, pad_select, pad_clear);
        end
        cbrm_pkg::IO_IRQ: begin
          target_next = cbrm_pkg::T_IRQ;
          devoff_next = {2'b0, addr_q[1:0]};
        end
        default: begin
          if (!func_q) rd_next = cbrm_pkg::OPEN_BUS;
        end
      endcase
    end else begin
      if (!func_q) rd_next = cbrm_pkg::OPEN_BUS;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      target        <= target_next;
      read_data     <= rd_next;
      rom_address   <= romaddr_next;
      device_offset <= devoff_next;
      is_write      <= func_q;
    end
  end

  `ASSERT_SAME(a_done_after_finish, done, $past(state) == S_DONE, "done without finish state")
  `ASSERT_NEXT(a_accept_decodes, start && !busy, state == S_DECODE, "accepted item not decoded")
  `ASSERT_NEXT(a_div_counts, state == S_DIV && cnt != 5'd0,
               state == S_DIV && cnt == $past(cnt) - 5'd1, "divide step count slipped")
  `ASSERT_SAME(a_rom_in_image, done && !is_write && target == cbrm_pkg::T_ROM,
               {1'b0, rom_address} < size_img, "rom fetch beyond image")
  `ASSERT_SAME(a_open_read_ff, done && !is_write && target == cbrm_pkg::T_OPEN,
               read_data == cbrm_pkg::OPEN_BUS, "open bus read not 0xFF")

endmodule
